// ===== src/rqrp_pkg.sv =====
package rqrp_pkg;

    localparam int MAX_TASKS = 64;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int SCAN_W    = $clog2(MAX_TASKS + 2);
    localparam int TASK_W    = 6;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int SEED_W    = 64;

    localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SM_MUL1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SM_MUL2  = 64'h94D049BB133111EB;
    localparam int SM_SH1 = 30;
    localparam int SM_SH2 = 27;
    localparam int SM_SH3 = 31;

    localparam logic [MODE_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] OP_PICK   = 2'd1;
    localparam logic [MODE_W-1:0] OP_UNLINK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED    = 2'd1;

    typedef struct packed {
        logic              push_en;
        logic              remove_en;
        logic              clear;
        logic              unlink;
        logic [TASK_W-1:0] task_id;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  pos;
    } cell_ctrl_t;

endpackage

// ===== src/rqrp_cell.sv =====
module rqrp_cell import rqrp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IDX_W-1:0]  idx,
    input  cell_ctrl_t        ctrl,
    input  logic [TASK_W-1:0] next_entry,
    input  logic              hit_in,
    input  logic [TASK_W-1:0] carry_in,
    output logic [TASK_W-1:0] entry,
    output logic              hit_out,
    output logic [TASK_W-1:0] carry_out
);

    logic [TASK_W-1:0] entry_reg;
    logic              hit_reg;
    logic [TASK_W-1:0] carry_reg;
    logic              in_range;
    logic              tgt;

    assign in_range = CNT_W'(idx) < ctrl.count;
    assign tgt = ctrl.unlink ? ((entry_reg == ctrl.task_id) && in_range)
                             : (CNT_W'(idx) == ctrl.pos);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_in | tgt;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            carry_reg <= '0;
        end else begin
            carry_reg <= tgt ? entry_reg : carry_in;
        end
        if (ctrl.push_en && (CNT_W'(idx) == ctrl.count)) begin
            entry_reg <= ctrl.task_id;
        end else if (ctrl.remove_en && (hit_in || tgt) && in_range) begin
            entry_reg <= next_entry;
        end
    end

    assign entry     = entry_reg;
    assign hit_out   = hit_reg;
    assign carry_out = carry_reg;

endmodule

// ===== src/rqrp_rng.sv =====
module rqrp_rng import rqrp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        seed_load,
    input  logic [63:0] seed,
    input  logic        start,
    output logic        done,
    output logic [63:0] z
);

    typedef enum logic [3:0] {
        RNG_IDLE = 4'b0001,
        RNG_MUL1 = 4'b0010,
        RNG_MUL2 = 4'b0100,
        RNG_OUT  = 4'b1000
    } rng_state_t;

    rng_state_t  state_reg, state_next;
    logic [63:0] gen_reg;
    logic [63:0] opa_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic [63:0] z_reg;
    logic [1:0]  step_reg;
    logic [63:0] gen_sum;
    logic [63:0] opb;
    logic [31:0] ma, mb;
    logic [63:0] addend;
    logic [63:0] fin;

    assign gen_sum = gen_reg + SM_GAMMA;
    assign opb     = (state_reg == RNG_MUL2) ? SM_MUL2 : SM_MUL1;

    always_comb begin
        case (step_reg)
            2'd0: begin
                ma = opa_reg[31:0];
                mb = opb[31:0];
            end
            2'd1: begin
                ma = opa_reg[31:0];
                mb = opb[63:32];
            end
            default: begin
                ma = opa_reg[63:32];
                mb = opb[31:0];
            end
        endcase
    end

    assign addend = (step_reg == 2'd1) ? prod_reg : {prod_reg[31:0], 32'b0};
    assign fin    = acc_reg + addend;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            RNG_IDLE: if (start) state_next = RNG_MUL1;
            RNG_MUL1: if (step_reg == 2'd3) state_next = RNG_MUL2;
            RNG_MUL2: if (step_reg == 2'd3) state_next = RNG_OUT;
            RNG_OUT:  state_next = RNG_IDLE;
            default:  state_next = RNG_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RNG_IDLE;
            gen_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (seed_load) begin
                gen_reg <= seed;
            end else if (state_reg == RNG_IDLE && start) begin
                gen_reg <= gen_sum;
            end
            if (state_reg == RNG_MUL1 || state_reg == RNG_MUL2) begin
                step_reg <= step_reg + 2'd1;
            end else begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(ma) * 64'(mb);
        case (state_reg)
            RNG_IDLE: begin
                opa_reg <= gen_sum ^ (gen_sum >> SM_SH1);
                acc_reg <= '0;
            end
            RNG_MUL1, RNG_MUL2: begin
                if (step_reg == 2'd3) begin
                    acc_reg <= '0;
                    if (state_reg == RNG_MUL1) begin
                        opa_reg <= fin ^ (fin >> SM_SH2);
                    end else begin
                        z_reg <= fin ^ (fin >> SM_SH3);
                    end
                end else if (step_reg != 2'd0) begin
                    acc_reg <= fin;
                end
            end
            default: acc_reg <= '0;
        endcase
    end

    assign done = (state_reg == RNG_OUT);
    assign z    = z_reg;

endmodule

// ===== src/rqrp_mod.sv =====
module rqrp_mod import rqrp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [63:0]      dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [CNT_W-1:0] rem
);

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       bit_reg;
    logic [63:0]      dvd_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W:0]   trial;

    assign trial = {rem_reg, dvd_reg[63]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                bit_reg  <= '0;
            end else if (busy_reg) begin
                bit_reg <= bit_reg + 6'd1;
                if (bit_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_reg <= CNT_W'(trial - {1'b0, divisor});
            end else begin
                rem_reg <= trial[CNT_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== src/ready_queue_random_pick.sv =====
// Ready queue of task numbers with head or seeded random pick.
// Input beat on s_t*: tdata = {task_id, mode}; mode 0 push, 1 pick, 2 unlink.
// Result beat on m_t*: one per input beat, tdata = {entry_count, overflow,
// unlink_found, picked_valid, picked_id}.
// cfg_*: register writes (0 random_mode, 1 rng_seed); a seed write reloads
// the generator. cfg_ready is always high; write only while idle.
// One item at a time; the next beat is taken the cycle after the result beat.
// Push, an unused mode and a pick from an empty queue go straight to the output
// register. Head pick and unlink walk the cell chain. A random pick from more
// than one entry first runs the splitmix step (two 64-bit products from 32x32
// partials) and then the 64-step remainder unit.
// A result waits in the output register until m_tready; no new beat is taken
// meanwhile. Reset empties the queue, clears random_mode and seeds zero.
module ready_queue_random_pick import rqrp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // mode[1:0], task_id[7:2]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // picked_id[5:0], picked_valid[6],
                                            // unlink_found[7], overflow[8],
                                            // entry_count[15:9]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEED_W-1:0]    cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RNG  = 5'b00010,
        ST_MOD  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              random_reg;
    logic [TASK_W-1:0] task_reg;
    logic              unlink_reg, unlink_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [SCAN_W-1:0] scan_reg;
    logic [15:0]       res_reg, res_next;

    logic              in_acc;
    logic [MODE_W-1:0] in_mode;
    logic [TASK_W-1:0] in_task;
    logic              scan_end;
    logic              rng_start, rng_done, mod_done;
    logic [63:0]       rng_z;
    logic [CNT_W-1:0]  mod_rem;
    cell_ctrl_t        ctrl;

    logic [TASK_W-1:0] entry_w [MAX_TASKS];
    logic              hit_w   [MAX_TASKS];
    logic [TASK_W-1:0] carry_w [MAX_TASKS];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign in_mode   = s_tdata[MODE_W-1:0];
    assign in_task   = s_tdata[MODE_W +: TASK_W];
    assign cfg_ready = 1'b1;
    assign scan_end  = (state_reg == ST_SCAN) && (scan_reg == SCAN_W'(MAX_TASKS + 1));
    assign rng_start = in_acc && (in_mode == OP_PICK) && random_reg
                       && (count_reg > CNT_W'(1));

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        res_next    = res_reg;
        unlink_next = unlink_reg;
        pos_next    = pos_reg;
        ctrl.push_en   = 1'b0;
        ctrl.remove_en = 1'b0;
        ctrl.clear     = (state_reg == ST_SCAN) && (scan_reg == '0);
        ctrl.unlink    = unlink_reg;
        ctrl.task_id   = in_acc ? in_task : task_reg;
        ctrl.count     = count_reg;
        ctrl.pos       = pos_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    res_next    = {COUNT_W'(count_reg), 9'b0};
                    unlink_next = 1'b0;
                    pos_next    = '0;
                    state_next  = ST_OUT;
                    case (in_mode)
                        OP_PUSH: begin
                            if (count_reg >= CNT_W'(MAX_TASKS)) begin
                                res_next[8] = 1'b1;
                            end else begin
                                ctrl.push_en = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                res_next     = {COUNT_W'(count_next), 9'b0};
                            end
                        end
                        OP_PICK: begin
                            if (rng_start) begin
                                state_next = ST_RNG;
                            end else if (count_reg != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_UNLINK: begin
                            unlink_next = 1'b1;
                            state_next  = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RNG: if (rng_done) state_next = ST_MOD;
            ST_MOD: begin
                if (mod_done) begin
                    pos_next   = mod_rem;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_OUT;
                    if (unlink_reg) begin
                        ctrl.remove_en = hit_w[MAX_TASKS-1];
                        res_next = {COUNT_W'(count_reg - CNT_W'(hit_w[MAX_TASKS-1])),
                                    1'b0, hit_w[MAX_TASKS-1], 1'b0, TASK_W'(0)};
                    end else begin
                        ctrl.remove_en = 1'b1;
                        res_next = {COUNT_W'(count_reg - CNT_W'(1)), 1'b0, 1'b0, 1'b1,
                                    carry_w[MAX_TASKS-1]};
                    end
                    if (ctrl.remove_en) count_next = count_reg - CNT_W'(1);
                end
            end
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            random_reg <= 1'b0;
            scan_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_index == REG_RANDOM_MODE) random_reg <= cfg_data[0];
            if (state_reg == ST_SCAN) begin
                scan_reg <= scan_reg + SCAN_W'(1);
            end else begin
                scan_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        unlink_reg <= unlink_next;
        pos_reg    <= pos_next;
        if (in_acc) task_reg <= in_task;
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = res_reg;

    rqrp_rng u_rng (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed_load (cfg_valid && cfg_index == REG_RNG_SEED),
        .seed      (cfg_data),
        .start     (rng_start),
        .done      (rng_done),
        .z         (rng_z)
    );

    rqrp_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rng_done),
        .dividend (rng_z),
        .divisor  (count_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        rqrp_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .idx        (IDX_W'(k)),
            .ctrl       (ctrl),
            .next_entry ((k == MAX_TASKS - 1) ? TASK_W'(0) : entry_w[(k + 1) % MAX_TASKS]),
            .hit_in     ((k == 0) ? 1'b0 : hit_w[(k + MAX_TASKS - 1) % MAX_TASKS]),
            .carry_in   ((k == 0) ? TASK_W'(0) : carry_w[(k + MAX_TASKS - 1) % MAX_TASKS]),
            .entry      (entry_w[k]),
            .hit_out    (hit_w[k]),
            .carry_out  (carry_w[k])
        );
    end

endmodule
